FILE: src/swm_pkg.sv
// Shared constants and types for the 2-D sliding-window minimum filter.
package swm_pkg;

   // Default build-time sizes
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_WIN_W  = 16;
   localparam int DEF_MAX_WIN_H  = 16;
   localparam int DEF_PIXEL_BITS = 16;

   // Frame height limit (not a build option)
   localparam int MAX_HEIGHT = 1024;

   // Beat field widths
   localparam int PIX_W = 16;
   localparam int POS_W = 10;

   // CSR field widths and reset values
   localparam int CFG_DIM_W = 11;
   localparam int CFG_WIN_W = 5;
   localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH   = 11'd1024;
   localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT  = 11'd1024;
   localparam logic [CFG_WIN_W-1:0] RST_WINDOW_WIDTH  = 5'd3;
   localparam logic [CFG_WIN_W-1:0] RST_WINDOW_HEIGHT = 5'd3;

   // APB port
   localparam int APB_ADDR_W = 4;
   localparam int APB_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH   = 2'd0,
      REG_IMAGE_HEIGHT  = 2'd1,
      REG_WINDOW_WIDTH  = 2'd2,
      REG_WINDOW_HEIGHT = 2'd3
   } csr_index_type;

endpackage

FILE: src/swm_ifs.sv
// Valid/ready channel interfaces for pixel input and window result beats.
interface swm_req_if;
   logic                      valid;
   logic                      ready;
   logic [swm_pkg::PIX_W-1:0] pixel_value;
   logic                      frame_start;

   modport source (output valid, output pixel_value, output frame_start, input ready);
   modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface swm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [swm_pkg::PIX_W-1:0] window_min;
   logic [swm_pkg::POS_W-1:0] out_row;
   logic [swm_pkg::POS_W-1:0] out_col;
   logic                      frame_last;

   modport source (output valid, output window_min, output out_row, output out_col,
                   output frame_last, input ready);
   modport sink   (input valid, input window_min, input out_row, input out_col,
                   input frame_last, output ready);
endinterface

FILE: src/swm_row_window.sv
// Horizontal run: shift line of recent pixels and masked minimum tree.
module swm_row_window #(
   parameter int MAX_WIN_W  = swm_pkg::DEF_MAX_WIN_W,
   parameter int PIXEL_BITS = swm_pkg::DEF_PIXEL_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift_en,
   input  logic [PIXEL_BITS-1:0]          pixel,
   input  logic [$clog2(MAX_WIN_W+1)-1:0] win_w,
   output logic [PIXEL_BITS-1:0]          run_min
);

   localparam int TAPS = (MAX_WIN_W > 1) ? MAX_WIN_W - 1 : 1;
   localparam int TN   = 1 << $clog2(TAPS + 1);

   logic [PIXEL_BITS-1:0] taps_ff [TAPS];
   logic [PIXEL_BITS-1:0] tree    [TN];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS; k++) taps_ff[k] <= '0;
      end else if (shift_en) begin
         taps_ff[0] <= pixel;
         for (int k = 1; k < TAPS; k++) taps_ff[k] <= taps_ff[k-1];
      end
   end

   // leaf 0 is the new pixel; taps outside the window read as all ones
   always_comb begin
      for (int i = 0; i < TN; i++) tree[i] = '1;
      tree[0] = pixel;
      for (int k = 0; k < TAPS; k++) begin
         if ((k + 1) < int'(win_w)) tree[k+1] = taps_ff[k];
      end
      for (int s = TN / 2; s >= 1; s = s / 2) begin
         for (int i = 0; i < s; i++) begin
            tree[i] = (tree[2*i+1] < tree[2*i]) ? tree[2*i+1] : tree[2*i];
         end
      end
      run_min = tree[0];
   end

endmodule

FILE: src/swm_line_store.sv
// Column-indexed line store: read, vertical minimum, shifted write-back.
module swm_line_store #(
   parameter int MAX_WIDTH  = swm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_WIN_H  = swm_pkg::DEF_MAX_WIN_H,
   parameter int PIXEL_BITS = swm_pkg::DEF_PIXEL_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
   input  logic                           upd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]   upd_addr,
   input  logic [PIXEL_BITS-1:0]          run_min,
   input  logic [$clog2(MAX_WIN_H+1)-1:0] win_h,
   output logic [PIXEL_BITS-1:0]          col_min
);

   localparam int LANES = (MAX_WIN_H > 1) ? MAX_WIN_H - 1 : 1;
   localparam int LW    = LANES * PIXEL_BITS;
   localparam int TN    = 1 << $clog2(LANES + 1);

   // one word per column: lane 0 is the newest row's run minimum
   logic [LW-1:0] mem [MAX_WIDTH];

   logic [LW-1:0]         rd_word_ff;
   logic [LW-1:0]         last_word_ff;
   logic                  fwd_hit_ff;
   logic [LW-1:0]         cur_word;
   logic [LW-1:0]         upd_word;
   logic [PIXEL_BITS-1:0] tree [TN];

   always_ff @(posedge clock) begin
      if (upd_en) mem[upd_addr] <= upd_word;
      if (rd_en)  rd_word_ff    <= mem[rd_addr];
   end

   // same-column read and write at one edge: the memory read sees old data, so flag a forward
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= upd_en && (upd_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (upd_en) last_word_ff <= upd_word;
   end

   assign cur_word = fwd_hit_ff ? last_word_ff : rd_word_ff;
   assign upd_word = LW'({cur_word, run_min});

   always_comb begin
      for (int i = 0; i < TN; i++) tree[i] = '1;
      tree[0] = run_min;
      for (int k = 0; k < LANES; k++) begin
         if ((k + 1) < int'(win_h)) tree[k+1] = cur_word[k*PIXEL_BITS +: PIXEL_BITS];
      end
      for (int s = TN / 2; s >= 1; s = s / 2) begin
         for (int i = 0; i < s; i++) begin
            tree[i] = (tree[2*i+1] < tree[2*i]) ? tree[2*i+1] : tree[2*i];
         end
      end
      col_min = tree[0];
   end

endmodule

FILE: src/sliding_window_min_2d.sv
// Path: an accepted pixel reaches its result beat through stage B, then the output
//   register; pixels with no full window give no beat.
// Throughput: one pixel per clock, set by the line store's one read and one write per cycle
//   (same-column back-to-back accesses are forwarded); a stalled result stalls stage B.
// Reset: position counters and row taps clear to zero, CSRs to their defaults; the line
//   store is not cleared and holds no meaning for a column until a row has passed it.
module sliding_window_min_2d #(
   parameter int MAX_WIDTH  = swm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_WIN_W  = swm_pkg::DEF_MAX_WIN_W,
   parameter int MAX_WIN_H  = swm_pkg::DEF_MAX_WIN_H,
   parameter int PIXEL_BITS = swm_pkg::DEF_PIXEL_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   swm_req_if.sink                           req_ch,
   swm_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [swm_pkg::APB_ADDR_W-1:0]    csr_paddr,
   input  logic [swm_pkg::APB_DATA_W-1:0]    csr_pwdata,
   output logic [swm_pkg::APB_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int CW  = $clog2(MAX_WIDTH);        // column counter / line store address
   localparam int WB  = $clog2(MAX_WIDTH + 1);    // effective image width
   localparam int WWB = $clog2(MAX_WIN_W + 1);    // effective window width
   localparam int WHB = $clog2(MAX_WIN_H + 1);    // effective window height
   localparam int CDW = (CW + 1 > WWB) ? CW + 1 : WWB;

   // ---------------------------------------------------------------------------------
   // CSR block
   // ---------------------------------------------------------------------------------
   logic [swm_pkg::CFG_DIM_W-1:0] img_w_ff, img_w_in;
   logic [swm_pkg::CFG_DIM_W-1:0] img_h_ff, img_h_in;
   logic [swm_pkg::CFG_WIN_W-1:0] win_w_ff, win_w_in;
   logic [swm_pkg::CFG_WIN_W-1:0] win_h_ff, win_h_in;
   logic                          csr_wr;
   swm_pkg::csr_index_type        csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = swm_pkg::csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      img_w_in = img_w_ff;
      img_h_in = img_h_ff;
      win_w_in = win_w_ff;
      win_h_in = win_h_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            swm_pkg::REG_IMAGE_WIDTH:   img_w_in = csr_pwdata[swm_pkg::CFG_DIM_W-1:0];
            swm_pkg::REG_IMAGE_HEIGHT:  img_h_in = csr_pwdata[swm_pkg::CFG_DIM_W-1:0];
            swm_pkg::REG_WINDOW_WIDTH:  win_w_in = csr_pwdata[swm_pkg::CFG_WIN_W-1:0];
            swm_pkg::REG_WINDOW_HEIGHT: win_h_in = csr_pwdata[swm_pkg::CFG_WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= swm_pkg::RST_IMAGE_WIDTH;
         img_h_ff <= swm_pkg::RST_IMAGE_HEIGHT;
         win_w_ff <= swm_pkg::RST_WINDOW_WIDTH;
         win_h_ff <= swm_pkg::RST_WINDOW_HEIGHT;
      end else begin
         img_w_ff <= img_w_in;
         img_h_ff <= img_h_in;
         win_w_ff <= win_w_in;
         win_h_ff <= win_h_in;
      end
   end

   always_comb begin
      unique case (csr_idx)
         swm_pkg::REG_IMAGE_WIDTH:   csr_prdata = swm_pkg::APB_DATA_W'(img_w_ff);
         swm_pkg::REG_IMAGE_HEIGHT:  csr_prdata = swm_pkg::APB_DATA_W'(img_h_ff);
         swm_pkg::REG_WINDOW_WIDTH:  csr_prdata = swm_pkg::APB_DATA_W'(win_w_ff);
         swm_pkg::REG_WINDOW_HEIGHT: csr_prdata = swm_pkg::APB_DATA_W'(win_h_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // Effective sizes: zero acts as one, oversize values saturate at the build limits
   logic [WB-1:0]                 w_eff;
   logic [swm_pkg::CFG_DIM_W-1:0] h_eff;
   logic [WWB-1:0]                ww_eff;
   logic [WHB-1:0]                wh_eff;

   always_comb begin
      priority if (img_w_ff == '0)               w_eff = WB'(1);
      else if (32'(img_w_ff) > 32'(MAX_WIDTH))   w_eff = WB'(MAX_WIDTH);
      else                                       w_eff = WB'(img_w_ff);

      priority if (img_h_ff == '0)                          h_eff = 11'd1;
      else if (32'(img_h_ff) > 32'(swm_pkg::MAX_HEIGHT))    h_eff = 11'(swm_pkg::MAX_HEIGHT);
      else                                                  h_eff = img_h_ff;

      priority if (win_w_ff == '0)               ww_eff = WWB'(1);
      else if (32'(win_w_ff) > 32'(MAX_WIN_W))   ww_eff = WWB'(MAX_WIN_W);
      else                                       ww_eff = WWB'(win_w_ff);

      priority if (win_h_ff == '0)               wh_eff = WHB'(1);
      else if (32'(win_h_ff) > 32'(MAX_WIN_H))   wh_eff = WHB'(MAX_WIN_H);
      else                                       wh_eff = WHB'(win_h_ff);
   end

   // ---------------------------------------------------------------------------------
   // Stage A: accept beat, resolve raster position, start line store read
   // ---------------------------------------------------------------------------------
   logic                  req_fire;
   logic [CW-1:0]         col_cnt_ff;
   logic [swm_pkg::POS_W-1:0] row_cnt_ff;
   logic [CW-1:0]         col_a;
   logic [swm_pkg::POS_W-1:0] row_a;
   logic [CW:0]           col_p1;
   logic [swm_pkg::POS_W:0]   row_p1;
   logic                  row_end;
   logic                  win_full;
   logic                  last_a;
   logic [CDW-1:0]        col_diff;
   logic [swm_pkg::POS_W:0]   row_diff;
   logic [PIXEL_BITS-1:0] pix_a;
   logic [PIXEL_BITS-1:0] run_min_a;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign pix_a    = PIXEL_BITS'(req_ch.pixel_value);

   // frame_start forces this pixel to the frame origin
   assign col_a    = req_ch.frame_start ? '0 : col_cnt_ff;
   assign row_a    = req_ch.frame_start ? '0 : row_cnt_ff;
   assign col_p1   = (CW+1)'(col_a) + (CW+1)'(1);
   assign row_p1   = (swm_pkg::POS_W+1)'(row_a) + (swm_pkg::POS_W+1)'(1);
   assign row_end  = col_p1 >= (CW+1)'(w_eff);
   assign win_full = (CDW'(col_p1) >= CDW'(ww_eff)) &&
                     (row_p1 >= (swm_pkg::POS_W+1)'(wh_eff));
   assign last_a   = row_end && (row_p1 >= h_eff);
   assign col_diff = CDW'(col_p1) - CDW'(ww_eff);
   assign row_diff = row_p1 - (swm_pkg::POS_W+1)'(wh_eff);

   // raster position advance; a column past a shrunk width wraps at once, a row at row end
   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (req_fire) begin
         if (row_end) begin
            col_cnt_ff <= '0;
            row_cnt_ff <= (row_p1 >= h_eff) ? '0 : row_p1[swm_pkg::POS_W-1:0];
         end else begin
            col_cnt_ff <= col_p1[CW-1:0];
            row_cnt_ff <= row_a;
         end
      end
   end

   swm_row_window #(
      .MAX_WIN_W  (MAX_WIN_W),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_row_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (req_fire),
      .pixel    (pix_a),
      .win_w    (ww_eff),
      .run_min  (run_min_a)
   );

   // ---------------------------------------------------------------------------------
   // Stage B: line store data back, vertical minimum, write-back of the column
   // ---------------------------------------------------------------------------------
   logic                      b_valid_ff;
   logic                      b_emit_ff;
   logic                      b_last_ff;
   logic [CW-1:0]             b_addr_ff;
   logic [swm_pkg::POS_W-1:0] b_row_ff;
   logic [swm_pkg::POS_W-1:0] b_col_ff;
   logic [PIXEL_BITS-1:0]     b_rmin_ff;
   logic                      b_adv;
   logic [PIXEL_BITS-1:0]     col_min_b;
   logic                      out_valid_ff;

   // a beat without a result never waits on the output register
   assign b_adv        = b_valid_ff && (!b_emit_ff || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !b_valid_ff || b_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (req_fire) begin
         b_valid_ff <= 1'b1;
      end else if (b_adv) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_emit_ff <= win_full;
         b_last_ff <= last_a;
         b_addr_ff <= col_a;
         b_row_ff  <= row_diff[swm_pkg::POS_W-1:0];
         b_col_ff  <= swm_pkg::POS_W'(col_diff);
         b_rmin_ff <= run_min_a;
      end
   end

   swm_line_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WIN_H  (MAX_WIN_H),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_line_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (col_a),
      .upd_en   (b_adv),
      .upd_addr (b_addr_ff),
      .run_min  (b_rmin_ff),
      .win_h    (wh_eff),
      .col_min  (col_min_b)
   );

   // ---------------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------------
   logic [swm_pkg::PIX_W-1:0] out_min_ff;
   logic [swm_pkg::POS_W-1:0] out_row_ff;
   logic [swm_pkg::POS_W-1:0] out_col_ff;
   logic                      out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (b_adv && b_emit_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv && b_emit_ff) begin
         out_min_ff  <= swm_pkg::PIX_W'(col_min_b);
         out_row_ff  <= b_row_ff;
         out_col_ff  <= b_col_ff;
         out_last_ff <= b_last_ff;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.window_min = out_min_ff;
   assign rsp_ch.out_row    = out_row_ff;
   assign rsp_ch.out_col    = out_col_ff;
   assign rsp_ch.frame_last = out_last_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   // input back-pressure only ever comes from a blocked stage B
   a_ready_low_means_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (b_valid_ff && b_emit_ff && out_valid_ff))
      else $error("input stalled without a blocked result");

   // every accepted pixel occupies stage B on the next cycle
   a_accept_fills_b: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> b_valid_ff)
      else $error("accepted pixel lost before stage B");

   // a stalled stage B keeps its column, so the pending write-back address holds
   a_b_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_adv) |=> (b_valid_ff && $stable(b_addr_ff) && $stable(b_rmin_ff)))
      else $error("stage B changed while stalled");

endmodule

FILE: verif/testbench.sv
// Testbench for the 2-D sliding-window minimum filter: directed table, then random frames.
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_W         = swm_pkg::DEF_MAX_WIDTH;
   localparam int WIN_W_MAX     = swm_pkg::DEF_MAX_WIN_W;
   localparam int WIN_H_MAX     = swm_pkg::DEF_MAX_WIN_H;
   localparam int IDLE_LIMIT    = 1000;   // cycles with no beat, csr access or accept
   localparam int RANDOM_PIXELS = 300;

   // One result beat, in port order.
   typedef struct packed {
      logic [swm_pkg::PIX_W-1:0] window_min;
      logic [swm_pkg::POS_W-1:0] row;
      logic [swm_pkg::POS_W-1:0] col;
      logic                      last;
   } window_type;

   typedef enum logic {ROW_CSR, ROW_PIXEL} row_kind_type;

   // One line of the directed table: either a register write or a pixel beat.
   typedef struct {
      row_kind_type                   kind;
      swm_pkg::csr_index_type         reg_idx;
      logic [swm_pkg::APB_DATA_W-1:0] value;
      logic [swm_pkg::PIX_W-1:0]      pixel;
      logic                           sof;
      bit                             typed;   // want holds a hand-written result
      window_type                     want;
   } stim_row_type;

   logic clock;
   logic reset;

   swm_req_if req_ch();
   swm_rsp_if rsp_ch();

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [swm_pkg::APB_ADDR_W-1:0] csr_paddr;
   logic [swm_pkg::APB_DATA_W-1:0] csr_pwdata;
   logic [swm_pkg::APB_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   sliding_window_min_2d uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------
   // Predictor state: config copy, raster position, row taps and the
   // per-column history of run minima (newest line first).
   // ------------------------------------------------------------------
   logic [swm_pkg::CFG_DIM_W-1:0] cfg_img_w;
   logic [swm_pkg::CFG_DIM_W-1:0] cfg_img_h;
   logic [swm_pkg::CFG_WIN_W-1:0] cfg_win_w;
   logic [swm_pkg::CFG_WIN_W-1:0] cfg_win_h;
   int unsigned                   at_col;
   int unsigned                   at_row;
   logic [swm_pkg::PIX_W-1:0]     row_taps [WIN_W_MAX];
   logic [swm_pkg::PIX_W-1:0]     run_min_lines [WIN_H_MAX][MAX_W];

   window_type   pending_windows[$];   // expected result beats, oldest first
   stim_row_type plan[$];              // directed table
   int           errors;
   int           idle_cycles;
   int           random_sent;
   bit           calm;                 // no idling on either side

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Zero and oversize register values fold into the legal range.
   function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // Advance the predictor by one pixel; returns 1 when a full window ends here.
   function automatic bit predict_window(logic [swm_pkg::PIX_W-1:0] pix, logic sof,
                                         output window_type res);
      int unsigned               w, h, ww, wh, col, row;
      logic [swm_pkg::PIX_W-1:0] run_min, win_min;
      bit                        hit;
      w  = eff_size(cfg_img_w, MAX_W);
      h  = eff_size(cfg_img_h, swm_pkg::MAX_HEIGHT);
      ww = eff_size(cfg_win_w, WIN_W_MAX);
      wh = eff_size(cfg_win_h, WIN_H_MAX);
      if (sof) begin
         at_col = 0;
         at_row = 0;
      end
      col = (at_col >= MAX_W) ? MAX_W - 1 : at_col;
      row = at_row;

      // horizontal run, then down the column history
      run_min = pix;
      for (int k = 0; k + 1 < ww; k++)
         if (row_taps[k] < run_min) run_min = row_taps[k];
      win_min = run_min;
      for (int k = 0; k + 1 < wh; k++)
         if (run_min_lines[k][col] < win_min) win_min = run_min_lines[k][col];

      hit = (col + 1 >= ww) && (row + 1 >= wh);
      res.window_min = win_min;
      res.row        = swm_pkg::POS_W'(row + 1 - wh);
      res.col        = swm_pkg::POS_W'(col + 1 - ww);
      res.last       = (row + 1 >= h) && (col + 1 >= w);

      for (int k = WIN_W_MAX - 1; k > 0; k--) row_taps[k] = row_taps[k - 1];
      row_taps[0] = pix;
      for (int k = WIN_H_MAX - 1; k > 0; k--)
         run_min_lines[k][col] = run_min_lines[k - 1][col];
      run_min_lines[0][col] = run_min;

      if (col + 1 >= w) begin
         at_col = 0;
         at_row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         at_col = col + 1;
         at_row = row;
      end
      return hit;
   endfunction

   task automatic log_mismatch(string what, window_type want, window_type got);
      errors++;
      if (errors <= 10)
         $display("%0t %s: want min=%h row=%0d col=%0d last=%b, got min=%h row=%0d col=%0d %s%b",
                  $time, what, want.window_min, want.row, want.col, want.last,
                  got.window_min, got.row, got.col, "last=", got.last);
   endtask

   // ------------------------------------------------------------------
   // Result checker: every accepted beat against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      window_type got;
      window_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.window_min, rsp_ch.out_row, rsp_ch.out_col, rsp_ch.frame_last};
         if (pending_windows.size() == 0) begin
            log_mismatch("unexpected beat", '0, got);
         end else begin
            want = pending_windows[0];
            pending_windows.delete(0);
            if (got.window_min !== want.window_min || got.row !== want.row ||
                got.col !== want.col || got.last !== want.last)
               log_mismatch("mismatch", want, got);
         end
      end
   end

   // Watchdog: any handshake or csr access resets the count.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result backpressure: random stall bursts between ready runs.
   initial begin
      int left;
      bit stall;
      rsp_ch.ready = 1'b0;
      left = 0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_ch.ready <= 1'b1;
         end else if (left == 0) begin
            stall = ($urandom_range(0, 2) == 0);
            left  = stall ? $urandom_range(0, 14) : $urandom_range(0, 39);
            rsp_ch.ready <= !stall;
         end else begin
            left--;
         end
      end
   end

   // ------------------------------------------------------------------
   // Drivers. All tasks enter and leave at a falling edge.
   // ------------------------------------------------------------------

   // APB write: setup, access, then idle with psel low, so back-to-back writes
   // never touch psel twice in the same step.
   task automatic csr_write(swm_pkg::csr_index_type idx, logic [swm_pkg::APB_DATA_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= swm_pkg::APB_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         swm_pkg::REG_IMAGE_WIDTH:   cfg_img_w = val[swm_pkg::CFG_DIM_W-1:0];
         swm_pkg::REG_IMAGE_HEIGHT:  cfg_img_h = val[swm_pkg::CFG_DIM_W-1:0];
         swm_pkg::REG_WINDOW_WIDTH:  cfg_win_w = val[swm_pkg::CFG_WIN_W-1:0];
         swm_pkg::REG_WINDOW_HEIGHT: cfg_win_h = val[swm_pkg::CFG_WIN_W-1:0];
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Stop sending, wait for every expected beat, then let pixels that make
   // no result leave stage B before anything else happens.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_windows.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One pixel beat. Random gaps before it; now and then a full drain.
   task automatic send_pixel(logic [swm_pkg::PIX_W-1:0] pix, logic sof, bit typed,
                             window_type want);
      int         gap;
      bit         drain;
      window_type res;
      gap   = 0;
      drain = 0;
      if (!calm) begin
         if ($urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
         if ($urandom_range(0, 149) == 0) begin
            drain = 1;
            if (gap == 0) gap = 1;
         end
      end
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
         while (drain && pending_windows.size() != 0) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.pixel_value <= pix;
      req_ch.frame_start <= sof;
      do @(posedge clock); while (!req_ch.ready);
      if (predict_window(pix, sof, res))
         pending_windows.insert(pending_windows.size(), typed ? want : res);
      @(negedge clock);
   endtask

   task automatic set_geometry(int unsigned iw, int unsigned ih, int unsigned ww,
                               int unsigned wh);
      wait_drained();
      csr_write(swm_pkg::REG_IMAGE_WIDTH, iw);
      csr_write(swm_pkg::REG_IMAGE_HEIGHT, ih);
      csr_write(swm_pkg::REG_WINDOW_WIDTH, ww);
      csr_write(swm_pkg::REG_WINDOW_HEIGHT, wh);
   endtask

   function automatic logic [swm_pkg::PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return swm_pkg::PIX_W'($urandom_range(0, 3));   // lots of ties
         default: return swm_pkg::PIX_W'($urandom);
      endcase
   endfunction

   // Zero and oversize values now and then; mostly small windows.
   function automatic int unsigned pick_window();
      case ($urandom_range(0, 11))
         0:       return 0;
         1:       return $urandom_range(WIN_W_MAX + 1, 31);
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   // Whole frames with random content, at most budget pixels. First beat of
   // the phase always opens a frame (the counters may sit anywhere after a
   // geometry change); later frames sometimes drop frame_start, and stray
   // frame_start beats show up mid-frame. Some phases stop partway through
   // an extra frame.
   task automatic run_frames(int unsigned iw, int unsigned ih, int unsigned ww, int unsigned wh,
                             int unsigned frames, int unsigned budget);
      int unsigned npix;
      int unsigned tail;
      int unsigned sent;
      logic        sof;
      set_geometry(iw, ih, ww, wh);
      npix = eff_size(iw, MAX_W) * eff_size(ih, swm_pkg::MAX_HEIGHT);
      sent = 0;
      for (int unsigned f = 0; f < frames; f++) begin
         for (int unsigned p = 0; p < npix && sent < budget; p++) begin
            if (p == 0) sof = (f == 0) || ($urandom_range(0, 9) != 0);
            else        sof = ($urandom_range(0, 49) == 0);
            send_pixel(random_pixel(), sof, 1'b0, '0);
            sent++;
         end
      end
      tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, npix) : 0;
      for (int unsigned p = 0; p < tail && sent < budget; p++) begin
         send_pixel(random_pixel(), 1'b0, 1'b0, '0);
         sent++;
      end
      random_sent += sent;
   endtask

   function automatic void add_csr(swm_pkg::csr_index_type idx,
                                   logic [swm_pkg::APB_DATA_W-1:0] val);
      stim_row_type r;
      r = '{kind: ROW_CSR, reg_idx: idx, value: val, pixel: '0, sof: 1'b0, typed: 1'b0, want: '0};
      plan.insert(plan.size(), r);
   endfunction

   function automatic void add_pixel(logic [swm_pkg::PIX_W-1:0] pix, logic sof, bit typed,
                                     window_type want);
      stim_row_type r;
      r = '{kind: ROW_PIXEL, reg_idx: swm_pkg::REG_IMAGE_WIDTH, value: '0, pixel: pix,
            sof: sof, typed: typed, want: want};
      plan.insert(plan.size(), r);
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.pixel_value = '0;
      req_ch.frame_start = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      random_sent        = 0;
      calm               = 1'b0;

      cfg_img_w = swm_pkg::RST_IMAGE_WIDTH;
      cfg_img_h = swm_pkg::RST_IMAGE_HEIGHT;
      cfg_win_w = swm_pkg::RST_WINDOW_WIDTH;
      cfg_win_h = swm_pkg::RST_WINDOW_HEIGHT;
      at_col    = 0;
      at_row    = 0;
      foreach (row_taps[k]) row_taps[k] = '0;
      foreach (run_min_lines[k, c]) run_min_lines[k][c] = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // All-zero registers: a 1x1 window on a 1x1 image, so each beat
      // comes straight back at row 0, column 0, marked last of frame.
      add_csr(swm_pkg::REG_IMAGE_WIDTH, 0);
      add_csr(swm_pkg::REG_IMAGE_HEIGHT, 0);
      add_csr(swm_pkg::REG_WINDOW_WIDTH, 0);
      add_csr(swm_pkg::REG_WINDOW_HEIGHT, 0);
      add_pixel(16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 10'd0, 10'd0, 1'b1});
      add_pixel(16'h0000, 1'b0, 1'b1, '{16'h0000, 10'd0, 10'd0, 1'b1});
      add_pixel(16'h8000, 1'b1, 1'b1, '{16'h8000, 10'd0, 10'd0, 1'b1});
      add_pixel(16'h0001, 1'b0, 1'b1, '{16'h0001, 10'd0, 10'd0, 1'b1});

      // 4x2 image, 2x2 window; second frame arrives without frame_start
      // and its one zero must show only in the windows that cover it.
      add_csr(swm_pkg::REG_IMAGE_WIDTH, 4);
      add_csr(swm_pkg::REG_IMAGE_HEIGHT, 2);
      add_csr(swm_pkg::REG_WINDOW_WIDTH, 2);
      add_csr(swm_pkg::REG_WINDOW_HEIGHT, 2);
      add_pixel(16'd5, 1'b1, 1'b0, '0);
      add_pixel(16'd3, 1'b0, 1'b0, '0);
      add_pixel(16'd9, 1'b0, 1'b0, '0);
      add_pixel(16'd1, 1'b0, 1'b0, '0);
      add_pixel(16'd7, 1'b0, 1'b0, '0);
      add_pixel(16'd2, 1'b0, 1'b0, '0);
      add_pixel(16'd8, 1'b0, 1'b0, '0);
      add_pixel(16'd4, 1'b0, 1'b0, '0);
      for (int p = 0; p < 8; p++) add_pixel((p == 2) ? 16'h0000 : 16'hFFFF, 1'b0, 1'b0, '0);

      // Oversize window (31 -> 16) on a 2x2 image: nothing comes out.
      add_csr(swm_pkg::REG_IMAGE_WIDTH, 2);
      add_csr(swm_pkg::REG_IMAGE_HEIGHT, 2);
      add_csr(swm_pkg::REG_WINDOW_WIDTH, 31);
      add_csr(swm_pkg::REG_WINDOW_HEIGHT, 31);
      for (int p = 0; p < 4; p++) add_pixel(16'h0000, p == 0, 1'b0, '0);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (i == 0 || plan[i - 1].kind == ROW_PIXEL) wait_drained();
            csr_write(plan[i].reg_idx, plan[i].value);
         end else begin
            send_pixel(plan[i].pixel, plan[i].sof, plan[i].typed, plan[i].want);
         end
      end

      // Random geometry, mostly small images.
      while (random_sent < RANDOM_PIXELS) begin
         run_frames(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8),
                    pick_window(), pick_window(), $urandom_range(1, 3),
                    RANDOM_PIXELS - random_sent);
      end

      // Widest window on a 20x3 image, two rows tall.
      run_frames(20, 3, 16, 2, 1, 60);
      // Tallest window (height written oversize) on two-pixel rows.
      run_frames(2, 20, 2, 31, 1, 40);
      // Oversize width -> 1024-pixel rows, widest window; head of the row only.
      run_frames(2047, 1, 16, 1, 1, 40);
      // Oversize height -> 1024 rows of one pixel, tallest window; no idling.
      calm = 1'b1;
      run_frames(1, 2047, 1, 16, 1, 40);

      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0 && pending_windows.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
